/* design/sal_pkg.sv */
// Shared types, constants and helpers for the sorted array linked list.
package sal_pkg;

    localparam int CAPACITY = 128;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int LINK_W   = SLOT_W + 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [LINK_W-1:0] NULL_LINK = {LINK_W{1'b1}};

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } t_status;

    typedef struct packed {
        t_op                opcode;
        logic signed [31:0] code;
        logic [63:0]        name_key;
        logic [7:0]         age;
        logic [7:0]         children;
    } t_in;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  entry_count;
    } t_out;

    typedef struct packed {
        logic [31:0] code;
        logic [63:0] name_key;
        logic [7:0]  age;
        logic [7:0]  children;
    } t_rec;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_FREE,
        S_INS_WALK,
        S_INS_LINK,
        S_INS_PREV,
        S_SRCH,
        S_DEL,
        S_DEL_UNLINK,
        S_DEL_FREE,
        S_OUT
    } t_state;

    function automatic logic f_is_slot(input logic [LINK_W-1:0] x);
        return x < LINK_W'(CAPACITY);
    endfunction

endpackage

/* design/sal_ram.sv */
// Generic simple dual port RAM with registered read.
module sal_ram #(
    parameter int W = 8,
    parameter int D = 128
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/sal_link_store.sv */
// Link store: link RAM with per-slot written flags that supply the reset chain.
module sal_link_store (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [sal_pkg::SLOT_W-1:0] i_rd_addr,
    input  logic                       i_we,
    input  logic [sal_pkg::SLOT_W-1:0] i_wr_addr,
    input  logic [sal_pkg::LINK_W-1:0] i_wr_data,
    output logic [sal_pkg::LINK_W-1:0] o_rd_data
);

    logic [sal_pkg::CAPACITY-1:0] r_vld;
    logic [sal_pkg::SLOT_W-1:0]   r_rd_addr;
    logic                         r_rd_vld;
    logic [sal_pkg::LINK_W-1:0]   ram_q;

    sal_ram #(
        .W(sal_pkg::LINK_W),
        .D(sal_pkg::CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_we),
        .i_waddr(i_wr_addr),
        .i_wdata(i_wr_data),
        .i_raddr(i_rd_addr),
        .o_rdata(ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
        r_rd_addr <= i_rd_addr;
    end

    always_comb begin
        if (r_rd_vld) begin
            o_rd_data = ram_q;
        end else if (r_rd_addr == sal_pkg::SLOT_W'(sal_pkg::CAPACITY - 1)) begin
            o_rd_data = sal_pkg::NULL_LINK;
        end else begin
            o_rd_data = sal_pkg::LINK_W'(r_rd_addr) + sal_pkg::LINK_W'(1);
        end
    end

endmodule

/* design/sorted_array_linked_list_top.sv */
// Top level of the sorted array linked list with free list.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+------------------------------
//  input   | i_in_valid  | o_in_stall  | i_in_data  (sal_pkg::t_in)
//  output  | o_out_valid | i_out_stall | o_out_data (sal_pkg::t_out)
//
// One item at a time; k list entries are visited, one record/link RAM read each.
// An insert takes a free slot, walks the list, links the new entry and, when it follows an
// entry, rewrites that entry's link; a found delete unlinks the entry and frees its slot.
// Reset takes effect at once: link written flags clear together, no sweep.
// The input stalls while an item is in work; a finished result waits in the
// output register, and the block holds its result until that register frees.
module sorted_array_linked_list_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sal_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output sal_pkg::t_out o_out_data
);

    sal_pkg::t_state r_state, n_state;
    sal_pkg::t_in    r_cmd, n_cmd;
    sal_pkg::t_out   r_res, n_res;
    sal_pkg::t_out   r_out, n_out;
    logic            r_out_vld, n_out_vld;

    logic [sal_pkg::LINK_W-1:0] r_head, n_head;
    logic [sal_pkg::LINK_W-1:0] r_free, n_free;
    logic [sal_pkg::LINK_W-1:0] r_cur, n_cur;
    logic [sal_pkg::LINK_W-1:0] r_prev, n_prev;
    logic [sal_pkg::LINK_W-1:0] r_ns, n_ns;
    logic [sal_pkg::LINK_W-1:0] r_nxt, n_nxt;
    logic [sal_pkg::CNT_W-1:0]  r_total, n_total;

    logic                       in_acc;
    logic                       out_load;
    logic [sal_pkg::SLOT_W-1:0] rd_addr;
    logic                       lnk_we;
    logic [sal_pkg::SLOT_W-1:0] lnk_waddr;
    logic [sal_pkg::LINK_W-1:0] lnk_wdata;
    logic [sal_pkg::LINK_W-1:0] link_rd;
    logic                       dat_we;
    sal_pkg::t_rec              dat_wdata;
    logic [$bits(sal_pkg::t_rec)-1:0] dat_q;
    sal_pkg::t_rec              rec_rd;
    logic                       key_less;
    logic                       code_hit;

    assign o_in_stall  = (r_state != sal_pkg::S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_load    = !r_out_vld || !i_out_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    assign rec_rd   = sal_pkg::t_rec'(dat_q);
    assign key_less = rec_rd.name_key < r_cmd.name_key;
    assign code_hit = rec_rd.code == r_cmd.code;

    sal_ram #(
        .W($bits(sal_pkg::t_rec)),
        .D(sal_pkg::CAPACITY)
    ) u_dat_ram (
        .i_clk  (i_clk),
        .i_we   (dat_we),
        .i_waddr(r_free[sal_pkg::SLOT_W-1:0]),
        .i_wdata(dat_wdata),
        .i_raddr(rd_addr),
        .o_rdata(dat_q)
    );

    sal_link_store u_link (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_addr(rd_addr),
        .i_we     (lnk_we),
        .i_wr_addr(lnk_waddr),
        .i_wr_data(lnk_wdata),
        .o_rd_data(link_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sal_pkg::S_IDLE;
            r_head    <= sal_pkg::NULL_LINK;
            r_free    <= '0;
            r_total   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_free    <= n_free;
            r_total   <= n_total;
            r_out_vld <= n_out_vld;
        end
        r_cmd  <= n_cmd;
        r_res  <= n_res;
        r_out  <= n_out;
        r_cur  <= n_cur;
        r_prev <= n_prev;
        r_ns   <= n_ns;
        r_nxt  <= n_nxt;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sal_pkg::S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_data.opcode)
                        sal_pkg::OP_INSERT: begin
                            n_state = sal_pkg::f_is_slot(r_free) ? sal_pkg::S_INS_FREE
                                                                 : sal_pkg::S_OUT;
                        end
                        sal_pkg::OP_SEARCH: begin
                            n_state = sal_pkg::f_is_slot(r_head) ? sal_pkg::S_SRCH
                                                                 : sal_pkg::S_OUT;
                        end
                        sal_pkg::OP_DELETE: begin
                            n_state = sal_pkg::f_is_slot(r_head) ? sal_pkg::S_DEL
                                                                 : sal_pkg::S_OUT;
                        end
                        default: begin
                            n_state = sal_pkg::S_OUT;
                        end
                    endcase
                end
            end
            sal_pkg::S_INS_FREE: begin
                n_state = sal_pkg::f_is_slot(r_head) ? sal_pkg::S_INS_WALK
                                                     : sal_pkg::S_INS_LINK;
            end
            sal_pkg::S_INS_WALK: begin
                if (!(key_less && sal_pkg::f_is_slot(link_rd))) begin
                    n_state = sal_pkg::S_INS_LINK;
                end
            end
            sal_pkg::S_INS_LINK: begin
                n_state = sal_pkg::f_is_slot(r_prev) ? sal_pkg::S_INS_PREV
                                                     : sal_pkg::S_OUT;
            end
            sal_pkg::S_INS_PREV: begin
                n_state = sal_pkg::S_OUT;
            end
            sal_pkg::S_SRCH: begin
                if (code_hit || !sal_pkg::f_is_slot(link_rd)) begin
                    n_state = sal_pkg::S_OUT;
                end
            end
            sal_pkg::S_DEL: begin
                if (code_hit) begin
                    n_state = sal_pkg::S_DEL_UNLINK;
                end else if (!sal_pkg::f_is_slot(link_rd)) begin
                    n_state = sal_pkg::S_OUT;
                end
            end
            sal_pkg::S_DEL_UNLINK: begin
                n_state = sal_pkg::S_DEL_FREE;
            end
            sal_pkg::S_DEL_FREE: begin
                n_state = sal_pkg::S_OUT;
            end
            sal_pkg::S_OUT: begin
                if (out_load) begin
                    n_state = sal_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sal_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_cmd     = r_cmd;
        n_res     = r_res;
        n_head    = r_head;
        n_free    = r_free;
        n_cur     = r_cur;
        n_prev    = r_prev;
        n_ns      = r_ns;
        n_nxt     = r_nxt;
        n_total   = r_total;
        n_out     = r_out;
        n_out_vld = r_out_vld && i_out_stall;
        rd_addr   = r_cur[sal_pkg::SLOT_W-1:0];
        lnk_we    = 1'b0;
        lnk_waddr = r_ns[sal_pkg::SLOT_W-1:0];
        lnk_wdata = r_cur;
        dat_we    = 1'b0;
        dat_wdata = '{code:     i_in_data.code,
                      name_key: i_in_data.name_key,
                      age:      i_in_data.age,
                      children: i_in_data.children};
        unique case (r_state)
            sal_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_cmd  = i_in_data;
                    n_prev = sal_pkg::NULL_LINK;
                    n_cur  = r_head;
                    unique case (i_in_data.opcode)
                        sal_pkg::OP_INSERT: begin
                            if (sal_pkg::f_is_slot(r_free)) begin
                                dat_we  = 1'b1;
                                rd_addr = r_free[sal_pkg::SLOT_W-1:0];
                                n_ns    = r_free;
                            end else begin
                                n_res = '{status: sal_pkg::ST_FULL, slot: '0,
                                          entry_count: r_total};
                            end
                        end
                        sal_pkg::OP_SEARCH, sal_pkg::OP_DELETE: begin
                            rd_addr = r_head[sal_pkg::SLOT_W-1:0];
                            n_res   = '{status: sal_pkg::ST_MISS, slot: '0,
                                        entry_count: r_total};
                        end
                        default: begin
                            n_res = '{status: sal_pkg::ST_OK, slot: '0,
                                      entry_count: r_total};
                        end
                    endcase
                end
            end
            sal_pkg::S_INS_FREE: begin
                n_free  = link_rd;
                rd_addr = r_head[sal_pkg::SLOT_W-1:0];
            end
            sal_pkg::S_INS_WALK: begin
                if (key_less) begin
                    n_prev  = r_cur;
                    n_cur   = link_rd;
                    rd_addr = link_rd[sal_pkg::SLOT_W-1:0];
                end
            end
            sal_pkg::S_INS_LINK: begin
                lnk_we  = 1'b1;
                n_total = r_total + sal_pkg::CNT_W'(1);
                n_res   = '{status: sal_pkg::ST_OK, slot: r_ns[sal_pkg::SLOT_W-1:0],
                            entry_count: r_total + sal_pkg::CNT_W'(1)};
                if (!sal_pkg::f_is_slot(r_prev)) begin
                    n_head = r_ns;
                end
            end
            sal_pkg::S_INS_PREV: begin
                lnk_we    = 1'b1;
                lnk_waddr = r_prev[sal_pkg::SLOT_W-1:0];
                lnk_wdata = r_ns;
            end
            sal_pkg::S_SRCH: begin
                if (code_hit) begin
                    n_res = '{status: sal_pkg::ST_OK, slot: r_cur[sal_pkg::SLOT_W-1:0],
                              entry_count: r_total};
                end else begin
                    n_cur   = link_rd;
                    rd_addr = link_rd[sal_pkg::SLOT_W-1:0];
                end
            end
            sal_pkg::S_DEL: begin
                if (code_hit) begin
                    n_nxt = link_rd;
                end else begin
                    n_prev  = r_cur;
                    n_cur   = link_rd;
                    rd_addr = link_rd[sal_pkg::SLOT_W-1:0];
                end
            end
            sal_pkg::S_DEL_UNLINK: begin
                if (sal_pkg::f_is_slot(r_prev)) begin
                    lnk_we    = 1'b1;
                    lnk_waddr = r_prev[sal_pkg::SLOT_W-1:0];
                    lnk_wdata = r_nxt;
                end else begin
                    n_head = r_nxt;
                end
            end
            sal_pkg::S_DEL_FREE: begin
                lnk_we    = 1'b1;
                lnk_waddr = r_cur[sal_pkg::SLOT_W-1:0];
                lnk_wdata = r_free;
                n_free    = r_cur;
                if (r_total != '0) begin
                    n_total = r_total - sal_pkg::CNT_W'(1);
                end
                n_res = '{status: sal_pkg::ST_OK, slot: r_cur[sal_pkg::SLOT_W-1:0],
                          entry_count: (r_total != '0) ? r_total - sal_pkg::CNT_W'(1)
                                                       : r_total};
            end
            sal_pkg::S_OUT: begin
                if (out_load) begin
                    n_out_vld = 1'b1;
                    n_out     = r_res;
                end
            end
            default: begin
                n_out_vld = r_out_vld && i_out_stall;
            end
        endcase
    end

endmodule
